FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker of the heightmap block.
// No dependencies; the including module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSH_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSH_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/dsh_pkg.sv
// Shared types, constants and helper functions of the diamond-square heightmap block.
// No dependencies; every file of the block but dsh_ram and the macros imports this package.
package dsh_pkg;

	localparam int MAX_SIDE_LOG2 = 8;
	localparam int CW    = MAX_SIDE_LOG2 + 1;
	localparam int AW    = 2 * MAX_SIDE_LOG2;
	localparam int LW    = $clog2(MAX_SIDE_LOG2 + 1);
	localparam int HW    = 16;
	localparam int SW    = 16;
	localparam int ROW_W = 8;
	localparam int IDXW  = 2;
	localparam int CFGW  = 16;
	localparam int FRAC  = 14;
	localparam int SUMW  = HW + 2;
	localparam int PRODW = HW + SW + 1;
	localparam int SCLW  = PRODW - FRAC;
	localparam int TOTW  = SCLW + 1;
	localparam int READS = 4;

	localparam logic signed [HW-1:0]   ONE_FX  = HW'(16384);
	localparam logic signed [TOTW-1:0] TOT_ONE = TOTW'(16384);
	localparam logic [3:0] MAX_LG4 = 4'(MAX_SIDE_LOG2);

	localparam logic [IDXW-1:0] REG_SIDE_LOG2  = 2'd0;
	localparam logic [IDXW-1:0] REG_SEED_LOG2  = 2'd1;
	localparam logic [IDXW-1:0] REG_INIT_SCALE = 2'd2;

	localparam logic [3:0]    RST_SIDE_LOG2  = 4'd8;
	localparam logic [3:0]    RST_SEED_LOG2  = 4'd8;
	localparam logic [SW-1:0] RST_INIT_SCALE = 16'd16384;

	typedef enum logic [2:0] {
		PH_SEED    = 3'b001,
		PH_DIAMOND = 3'b010,
		PH_SQUARE  = 3'b100
	} phase_t;

	typedef struct packed {
		logic signed [HW-1:0] random_value;
		logic                 operation;
	} sample_t;

	typedef struct packed {
		logic [ROW_W-1:0]     row;
		logic [ROW_W-1:0]     col;
		logic signed [HW-1:0] height;
		logic                 last;
	} point_t;

	// One point of the map as handed from the sequencer to the datapath.
	typedef struct packed {
		logic [CW-1:0]        row;
		logic [CW-1:0]        col;
		logic [CW-1:0]        half;
		logic [LW-1:0]        lg;
		phase_t               phase;
		logic [SW-1:0]        scale;
		logic signed [HW-1:0] rnd;
		logic                 last;
	} job_t;

	// Linear store address of a point; coordinates wrap around the torus.
	function automatic logic [AW-1:0] cell_addr(logic [CW-1:0] r, logic [CW-1:0] c,
			logic [LW-1:0] lg);
		logic [CW-1:0] m;
		logic [AW-1:0] ra;
		m  = (CW'(1) << lg) - CW'(1);
		ra = AW'(r & m) << lg;
		return ra | AW'(c & m);
	endfunction

	function automatic logic signed [HW-1:0] clamp_one(logic signed [TOTW-1:0] v);
		logic signed [HW-1:0] res;
		if (v > TOT_ONE) begin
			res = ONE_FX;
		end else if (v < -TOT_ONE) begin
			res = -ONE_FX;
		end else begin
			res = HW'(v);
		end
		return res;
	endfunction

endpackage

FILE: rtl/core/dsh_ram.sv
// Generic simple dual-port RAM: one write and one registered read per cycle.
// A read of the address written in the same cycle returns the new data.
module dsh_ram #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= (we && (waddr == raddr)) ? wdata : mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: rtl/core/dsh_seq.sv
// Point sequencer: configuration registers and the walk over seed, diamond and square points.
// Depends on dsh_pkg.
module dsh_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [dsh_pkg::IDXW-1:0] cfg_index,
	input  logic [dsh_pkg::CFGW-1:0] cfg_data,
	input  logic                     take,
	input  dsh_pkg::sample_t         sample,
	output dsh_pkg::job_t            job
);
	import dsh_pkg::*;

	logic [3:0]    side_cfg_q;
	logic [3:0]    seed_cfg_q;
	logic [SW-1:0] scale_cfg_q;
	logic [LW-1:0] map_lg_q;
	logic [LW-1:0] sp_lg_q;
	logic [CW-1:0] row_q;
	logic [CW-1:0] col_q;
	phase_t        phase_q;
	logic [SW-1:0] scale_q;
	logic          pend_q;

	logic          start;
	logic [3:0]    side_sat;
	logic [3:0]    seed_sat;
	logic [LW-1:0] lg;
	logic [LW-1:0] sp_lg;
	logic [LW-1:0] nxt_sp_lg;
	logic [CW-1:0] side;
	logic [CW-1:0] spacing;
	logic [CW-1:0] half;
	logic [CW-1:0] r;
	logic [CW-1:0] c;
	logic [CW-1:0] r_step;
	logic [CW-1:0] c_step;
	logic [CW-1:0] r_half;
	logic [CW-1:0] nxt_r;
	logic [CW-1:0] nxt_c;
	logic [SW-1:0] scale;
	logic [SW-1:0] nxt_scale;
	phase_t        ph;
	phase_t        nxt_ph;
	logic          done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_cfg_q  <= RST_SIDE_LOG2;
			seed_cfg_q  <= RST_SEED_LOG2;
			scale_cfg_q <= RST_INIT_SCALE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIDE_LOG2:  side_cfg_q  <= cfg_data[3:0];
				REG_SEED_LOG2:  seed_cfg_q  <= cfg_data[3:0];
				REG_INIT_SCALE: scale_cfg_q <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	// A new map latches the saturated configuration.
	assign start    = sample.operation || pend_q;
	assign side_sat = (side_cfg_q < 4'd1) ? 4'd1 :
	                  (side_cfg_q > MAX_LG4) ? MAX_LG4 : side_cfg_q;
	assign seed_sat = (seed_cfg_q < 4'd1) ? 4'd1 :
	                  (seed_cfg_q > side_sat) ? side_sat : seed_cfg_q;

	assign lg    = start ? LW'(side_sat) : map_lg_q;
	assign sp_lg = start ? LW'(seed_sat) : sp_lg_q;
	assign scale = start ? scale_cfg_q : scale_q;
	assign ph    = start ? PH_SEED : phase_q;
	assign r     = start ? '0 : row_q;
	assign c     = start ? '0 : col_q;

	assign side    = CW'(1) << lg;
	assign spacing = CW'(1) << sp_lg;
	assign half    = spacing >> 1;
	assign r_step  = r + spacing;
	assign c_step  = c + spacing;
	assign r_half  = r + half;

	always_comb begin
		nxt_r     = r;
		nxt_c     = c;
		nxt_ph    = ph;
		nxt_sp_lg = sp_lg;
		nxt_scale = scale;
		done      = 1'b0;
		unique case (ph)
			PH_SEED: begin
				nxt_c = c_step;
				if (c_step >= side) begin
					nxt_c = '0;
					nxt_r = r_step;
					if (r_step >= side) begin
						nxt_ph = PH_DIAMOND;
						nxt_r  = half;
						nxt_c  = half;
					end
				end
			end
			PH_DIAMOND: begin
				nxt_r = r_step;
				if (r_step >= side) begin
					nxt_r = half;
					nxt_c = c_step;
					if (c_step >= side) begin
						nxt_ph = PH_SQUARE;
						nxt_r  = '0;
						nxt_c  = half;
					end
				end
			end
			PH_SQUARE: begin
				nxt_c = c_step;
				if (c_step >= side) begin
					nxt_r = r_half;
					if (r_half >= side) begin
						nxt_scale = scale >> 1;
						nxt_sp_lg = sp_lg - LW'(1);
						if (sp_lg == LW'(1)) begin
							done = 1'b1;
						end else begin
							nxt_ph = PH_DIAMOND;
							nxt_r  = half >> 1;
							nxt_c  = half >> 1;
						end
					end else begin
						// Square rows alternate between offset zero and offset half.
						nxt_c = (r_half + half) & (spacing - CW'(1));
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_lg_q <= LW'(MAX_SIDE_LOG2);
			sp_lg_q  <= LW'(MAX_SIDE_LOG2);
			row_q    <= '0;
			col_q    <= '0;
			phase_q  <= PH_SEED;
			scale_q  <= RST_INIT_SCALE;
			pend_q   <= 1'b1;
		end else if (take) begin
			map_lg_q <= lg;
			sp_lg_q  <= nxt_sp_lg;
			row_q    <= nxt_r;
			col_q    <= nxt_c;
			phase_q  <= nxt_ph;
			scale_q  <= nxt_scale;
			pend_q   <= done;
		end
	end

	assign job.row   = r;
	assign job.col   = c;
	assign job.half  = half;
	assign job.lg    = lg;
	assign job.phase = ph;
	assign job.scale = scale;
	assign job.rnd   = sample.random_value;
	assign job.last  = done;
endmodule

FILE: rtl/core/dsh_dp.sv
// Height datapath: four neighbor reads from the height memory, mean plus scaled noise, write back.
// Seeds write their clamped sample instead. Depends on dsh_pkg and dsh_ram.
module dsh_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  dsh_pkg::job_t  job,
	output logic           s1_free,
	output logic           push,
	output dsh_pkg::point_t result
);
	import dsh_pkg::*;

	localparam logic [1:0] K_LAST = 2'(READS - 1);

	logic                    v_s1;
	logic [1:0]              k_s1;
	job_t                    job_s1;
	logic signed [SUMW-1:0]  acc_s1;
	logic signed [PRODW-1:0] prod_s1;

	logic                    v_s2;
	logic signed [SUMW-1:0]  acc_s2;
	logic signed [SCLW-1:0]  scl_s2;
	logic                    seed_s2;
	logic signed [HW-1:0]    rnd_s2;
	logic [AW-1:0]           waddr_s2;
	logic [ROW_W-1:0]        row_s2;
	logic [ROW_W-1:0]        col_s2;
	logic                    last_s2;

	logic [CW-1:0]           nb_r;
	logic [CW-1:0]           nb_c;
	logic [AW-1:0]           raddr;
	logic signed [HW-1:0]    rdata;
	logic signed [SUMW-1:0]  rd_ext;
	logic signed [SUMW-1:0]  acc_nxt;
	logic signed [SUMW-1:0]  sum;
	logic signed [HW-1:0]    mean;
	logic signed [TOTW-1:0]  tot;
	logic signed [TOTW-1:0]  rnd_ext;
	logic signed [HW-1:0]    wdata;
	logic                    s1_end;

	dsh_ram #(
		.ADDR_W(AW),
		.DATA_W(HW)
	) u_ram (
		.clk  (clk),
		.we   (v_s2),
		.waddr(waddr_s2),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Neighbor k of the point in the read stage.
	always_comb begin
		nb_r = job_s1.row;
		nb_c = job_s1.col;
		if (job_s1.phase == PH_DIAMOND) begin
			nb_r = k_s1[0] ? job_s1.row + job_s1.half : job_s1.row - job_s1.half;
			nb_c = k_s1[1] ? job_s1.col + job_s1.half : job_s1.col - job_s1.half;
		end else begin
			unique case (k_s1)
				2'd0: nb_r = job_s1.row - job_s1.half;
				2'd1: nb_r = job_s1.row + job_s1.half;
				2'd2: nb_c = job_s1.col - job_s1.half;
				2'd3: nb_c = job_s1.col + job_s1.half;
			endcase
		end
	end

	assign raddr   = cell_addr(nb_r, nb_c, job_s1.lg);
	assign rd_ext  = $signed({{(SUMW - HW){rdata[HW-1]}}, rdata});
	assign acc_nxt = (k_s1 == 2'd1) ? rd_ext : acc_s1 + rd_ext;
	assign s1_end  = v_s1 && (k_s1 == K_LAST);
	assign s1_free = !v_s1 || (k_s1 == K_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			k_s1 <= '0;
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= s1_end;
			if (take) begin
				v_s1 <= 1'b1;
				k_s1 <= '0;
			end else if (v_s1) begin
				k_s1 <= k_s1 + 2'd1;
				if (k_s1 == K_LAST) begin
					v_s1 <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_s1 <= job;
		end
		acc_s1  <= acc_nxt;
		prod_s1 <= PRODW'(job_s1.rnd) * PRODW'($signed({1'b0, job_s1.scale}));
		if (s1_end) begin
			acc_s2   <= acc_nxt;
			scl_s2   <= SCLW'(prod_s1 >>> FRAC);
			seed_s2  <= (job_s1.phase == PH_SEED);
			rnd_s2   <= job_s1.rnd;
			waddr_s2 <= cell_addr(job_s1.row, job_s1.col, job_s1.lg);
			row_s2   <= ROW_W'(job_s1.row);
			col_s2   <= ROW_W'(job_s1.col);
			last_s2  <= job_s1.last;
		end
	end

	// The fourth neighbor arrives in the finishing cycle.
	assign sum     = acc_s2 + rd_ext;
	assign mean    = HW'(sum >>> 2);
	assign tot     = $signed({{(TOTW - HW){mean[HW-1]}}, mean}) +
	                 $signed({scl_s2[SCLW-1], scl_s2});
	assign rnd_ext = $signed({{(TOTW - HW){rnd_s2[HW-1]}}, rnd_s2});
	assign wdata   = seed_s2 ? clamp_one(rnd_ext) : clamp_one(tot);

	assign push          = v_s2;
	assign result.row    = row_s2;
	assign result.col    = col_s2;
	assign result.height = wdata;
	assign result.last   = last_s2;
endmodule

FILE: rtl/core/dsh_oq.sv
// Two-entry output queue that decouples the datapath from a stalled consumer.
// Depends on dsh_pkg.
module dsh_oq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dsh_pkg::point_t din,
	input  logic            stall,
	output logic            valid,
	output dsh_pkg::point_t dout
);
	import dsh_pkg::*;

	logic [1:0] cnt_q;
	point_t     head_q;
	point_t     tail_q;
	logic       pop;

	assign valid = (cnt_q != 2'd0);
	assign pop   = valid && !stall;
	assign dout  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				head_q <= tail_q;
				if (push) begin
					tail_q <= din;
				end
			end else if (push) begin
				head_q <= din;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= din;
			end else begin
				tail_q <= din;
			end
		end
	end
endmodule

FILE: rtl/core/diamond_square_heightmap_top.sv
// Top level of the toroidal diamond-square heightmap generator.
// Depends on dsh_pkg, dsh_seq, dsh_dp, dsh_ram and dsh_oq.
//
//   channel   direction  handshake                  request payload
//   sample    in         sample_valid/sample_stall  random_value, operation
//   point     out        point_valid/point_stall    row, col, height, last
//   cfg       in         cfg_we (no wait)           cfg_index, cfg_data
//
// When the output is free, a new request is taken while the previous point makes its last read:
// each point reads its four neighbors through the single read port of the height memory, one per cycle.
// An accepted request passes the read stage, the write stage and the output queue on its way out.
// Reset needs no clearing pass; the first request after reset starts a new map.
// A stalled output holds up to two points; sample_stall rises once two requests are outstanding.
module diamond_square_heightmap_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sample_valid,
	output logic                     sample_stall,
	input  dsh_pkg::sample_t         sample,
	output logic                     point_valid,
	input  logic                     point_stall,
	output dsh_pkg::point_t          point,
	input  logic                     cfg_we,
	input  logic [dsh_pkg::IDXW-1:0] cfg_index,
	input  logic [dsh_pkg::CFGW-1:0] cfg_data
);
	import dsh_pkg::*;

	job_t   job;
	point_t result;
	logic   take;
	logic   s1_free;
	logic   push;
	logic   pop;
	logic [1:0] inflight_q;

	// Requests are taken only when the read stage is free and the output queue is sure
	// to have room by the time this point finishes: at most one point may be ahead.
	assign sample_stall = !(s1_free && (inflight_q <= 2'd1));
	assign take         = sample_valid && !sample_stall;
	assign pop          = point_valid && !point_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 2'(take) - 2'(pop);
		end
	end

	// The sequencer names the point that each request produces and advances the walk.
	dsh_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.take     (take),
		.sample   (sample),
		.job      (job)
	);

	// The datapath gathers the neighbors, forms the height and writes it back.
	dsh_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.job    (job),
		.s1_free(s1_free),
		.push   (push),
		.result (result)
	);

	// Finished points wait here while the consumer stalls.
	dsh_oq u_oq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (result),
		.stall (point_stall),
		.valid (point_valid),
		.dout  (point)
	);
endmodule

FILE: rtl/core/dsh_chk.sv
// Port-level checker for the heightmap block, bound to the top level.
// Depends on dsh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dsh_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_valid,
	input logic             sample_stall,
	input dsh_pkg::sample_t sample,
	input logic             point_valid,
	input logic             point_stall,
	input dsh_pkg::point_t  point
);
	import dsh_pkg::*;

	logic [2:0] open_q;
	logic       take;
	logic       pop;

	assign take = sample_valid && !sample_stall;
	assign pop  = point_valid && !point_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 3'(take) - 3'(pop);
		end
	end

	`DSH_ASSERT_NEXT(a_point_hold, point_valid && point_stall, point_valid && $stable(point), "stalled point changed")
	`DSH_ASSERT_NOW(a_no_phantom, point_valid, open_q != 3'd0, "point without a pending request")
	`DSH_ASSERT_NOW(a_credit, take, open_q <= 3'd1, "request taken with no room")
	`DSH_ASSERT_NOW(a_height_range, point_valid, (point.height <= ONE_FX) && (point.height >= -ONE_FX), "height out of range")
endmodule

bind diamond_square_heightmap_top dsh_chk u_dsh_chk (.*);

FILE: tb/tb_diamond_square_heightmap_top.sv
// Self-checking testbench for the diamond-square heightmap generator top level.
// Depends on dsh_pkg and diamond_square_heightmap_top; predicts every point in-line.
`timescale 1ns / 1ps

module tb_diamond_square_heightmap_top;
	import dsh_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES   = 150;
	localparam int RANDOM_ITEMS  = 1030;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int TIMEOUT_NS    = 12_000_000;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                sample_valid = 1'b0;
	logic                sample_stall;
	sample_t             sample       = '0;
	logic                point_valid;
	logic                point_stall  = 1'b0;
	point_t              point;
	logic                cfg_we       = 1'b0;
	logic [IDXW-1:0]     cfg_index    = '0;
	logic [CFGW-1:0]     cfg_data     = '0;

	diamond_square_heightmap_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.point        (point),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Register file as seen by the generator. These values are only picked up
	// when a new map starts.
	logic [3:0]           side_cfg;
	logic [3:0]           seed_cfg;
	logic [15:0]          scale_cfg;

	// Mirror of the generator's working state for the map in progress.
	logic signed [HW-1:0] height_mem [0:(1 << AW) - 1];
	int unsigned          map_lg;
	int unsigned          spacing_now;
	int unsigned          row_now;
	int unsigned          col_now;
	int unsigned          scale_now;
	phase_t               phase_now;
	bit                   restart_due;

	// Points that have been requested and not yet seen at the output, oldest first.
	point_t               pending_points [$];
	point_t               last_point;
	int                   sent_count     = 0;
	int                   mismatch_count = 0;

	// Knobs shared by the stimulus and the output side. A percentage of zero
	// turns the random idling off for that side.
	int                   gap_pct   = 0;
	int                   stall_pct = 0;
	bit                   hold_wanted = 1'b0;

	// Latch the registers and rewind to the first seed. Both log2 values are
	// saturated: the side to [1, MAX_SIDE_LOG2], the seed spacing to [1, side].
	function automatic void start_map();
		int unsigned seed_lg;
		map_lg = side_cfg;
		if (map_lg < 1) map_lg = 1;
		if (map_lg > MAX_SIDE_LOG2) map_lg = MAX_SIDE_LOG2;
		seed_lg = seed_cfg;
		if (seed_lg < 1) seed_lg = 1;
		if (seed_lg > map_lg) seed_lg = map_lg;
		spacing_now = 1 << seed_lg;
		scale_now   = scale_cfg;
		phase_now   = PH_SEED;
		row_now     = 0;
		col_now     = 0;
		restart_due = 1'b0;
	endfunction

	// Stored height at a coordinate; both indices wrap around the torus.
	function automatic int stored_height(int unsigned r, int unsigned c);
		int unsigned m;
		m = (1 << map_lg) - 1;
		return height_mem[((r & m) << map_lg) | (c & m)];
	endfunction

	function automatic int clamp_height(int v);
		if (v > 16384) return 16384;
		if (v < -16384) return -16384;
		return v;
	endfunction

	// Enter the diamond pass of the next finer level; returns 1 when the map is complete.
	function automatic bit descend_level();
		if (spacing_now <= 1) return 1'b1;
		phase_now = PH_DIAMOND;
		row_now   = spacing_now >> 1;
		col_now   = spacing_now >> 1;
		return 1'b0;
	endfunction

	// Compute the point that one accepted request writes, and move the walk on.
	function automatic point_t next_map_point(sample_t s);
		int          rnd;
		int          sum;
		int          v;
		int unsigned side;
		int unsigned half;
		int unsigned r;
		int unsigned c;
		longint      prod;
		bit          done;
		point_t      p;
		rnd = $signed(s.random_value);
		if (s.operation || restart_due) start_map();
		side = 1 << map_lg;
		half = spacing_now >> 1;
		r    = row_now;
		c    = col_now;
		done = 1'b0;

		if (phase_now == PH_SEED) begin
			v = clamp_height(rnd);
		end else begin
			if (phase_now == PH_DIAMOND) begin
				sum = stored_height(r - half, c - half) + stored_height(r + half, c - half) +
					stored_height(r - half, c + half) + stored_height(r + half, c + half);
			end else begin
				sum = stored_height(r - half, c) + stored_height(r + half, c) +
					stored_height(r, c - half) + stored_height(r, c + half);
			end
			// Both the mean and the scaled sample round toward minus infinity.
			prod = longint'(rnd) * longint'(scale_now);
			v    = clamp_height((sum >>> 2) + int'(prod >>> FRAC));
		end
		height_mem[((r & (side - 1)) << map_lg) | (c & (side - 1))] = v[HW-1:0];

		// Walk order: seeds row by row, diamonds column by column, squares
		// row by row with the column offset alternating between rows.
		if (phase_now == PH_SEED) begin
			col_now += spacing_now;
			if (col_now >= side) begin
				col_now = 0;
				row_now += spacing_now;
				if (row_now >= side) done = descend_level();
			end
		end else if (phase_now == PH_DIAMOND) begin
			row_now += spacing_now;
			if (row_now >= side) begin
				row_now = half;
				col_now += spacing_now;
				if (col_now >= side) begin
					phase_now = PH_SQUARE;
					row_now   = 0;
					col_now   = half;
				end
			end
		end else begin
			col_now += spacing_now;
			if (col_now >= side) begin
				row_now += half;
				if (row_now >= side) begin
					scale_now   >>= 1;
					spacing_now >>= 1;
					done = descend_level();
				end else begin
					col_now = (row_now + half) & (spacing_now - 1);
				end
			end
		end
		if (done) restart_due = 1'b1;

		p.row    = r[ROW_W-1:0];
		p.col    = c[ROW_W-1:0];
		p.height = v[HW-1:0];
		p.last   = done;
		return p;
	endfunction

	// Mostly samples in the legal [-1, 1] range, with a quarter drawn from the
	// whole 16-bit range so that out-of-range samples and every bit get exercised.
	function automatic logic signed [HW-1:0] draw_value();
		logic [31:0] u;
		if ($urandom_range(0, 3) == 0) begin
			u = $urandom;
		end else begin
			u = $urandom_range(0, 32768) - 32'd16384;
		end
		return u[HW-1:0];
	endfunction

	// Offer one request and wait until the generator takes it. Valid stays high
	// on return so that back-to-back requests need no idle cycle.
	task automatic send_sample(input logic signed [HW-1:0] value, input logic op);
		sample_t s;
		int      gap;
		s.random_value = value;
		s.operation    = op;
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			sample_valid <= 1'b0;
			gap = $urandom_range(1, 15);
			repeat (gap) @(posedge clk);
		end
		sample       <= s;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
		last_point = next_map_point(s);
		pending_points.push_back(last_point);
		sent_count++;
	endtask

	// Stop offering requests, let every expected point come out, then give the
	// pipeline time to settle.
	task automatic wait_idle();
		sample_valid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [IDXW-1:0] idx, input logic [CFGW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SIDE_LOG2:  side_cfg  = value[3:0];
			REG_SEED_LOG2:  seed_cfg  = value[3:0];
			REG_INIT_SCALE: scale_cfg = value[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Send requests until the map reports its last point or the cap is hit.
	// Now and then a request restarts the map halfway through.
	task automatic run_map(input int max_items, input bit restart_first);
		bit op;
		for (int i = 0; i < max_items; i++) begin
			op = (i == 0) ? restart_first : ($urandom_range(0, 399) == 0);
			send_sample(draw_value(), op);
			if (last_point.last) break;
		end
	endtask

	// The first requests after reset must use the reset register values on a
	// 256 x 256 map with a single seed; extreme samples hit the clamp both ways.
	task automatic test_reset_defaults();
		gap_pct   = 0;
		stall_pct = 0;
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh4000, 1'b0);
		send_sample(-16'sh4000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh0001, 1'b0);
		send_sample(-16'sh0001, 1'b0);
		send_sample(16'sh3039, 1'b0);
		wait_idle();
	endtask

	// Out-of-range register values: side 0 and 15 saturate, seed spacing 15 and
	// 0 saturate, and scales of 2.0 and the largest 16-bit value are used as is.
	task automatic test_register_extremes();
		write_register(REG_SIDE_LOG2, 16'd0);
		write_register(REG_SEED_LOG2, 16'd15);
		write_register(REG_INIT_SCALE, 16'd32768);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		wait_idle();
		write_register(REG_SIDE_LOG2, 16'd15);
		write_register(REG_SEED_LOG2, 16'd0);
		write_register(REG_INIT_SCALE, 16'hFFFF);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh7FFF, 1'b0);
		wait_idle();
	endtask

	// A register write in the middle of a map must not disturb it; the new
	// side only applies once the map has ended and the next one starts.
	task automatic test_late_register_write();
		write_register(REG_SIDE_LOG2, 16'd1);
		write_register(REG_SEED_LOG2, 16'd1);
		write_register(REG_INIT_SCALE, 16'd16384);
		send_sample(16'sh2000, 1'b1);
		send_sample(-16'sh1000, 1'b0);
		wait_idle();
		write_register(REG_SIDE_LOG2, 16'd2);
		write_register(REG_SEED_LOG2, 16'd2);
		send_sample(16'sh0800, 1'b0);
		send_sample(-16'sh0800, 1'b0);
		send_sample(16'sh1234, 1'b0);
		send_sample(-16'sh1234, 1'b0);
		wait_idle();
	endtask

	// The output side holds off for a long stretch while requests keep coming,
	// so the internal buffer fills and sample_stall has to rise.
	task automatic test_output_hold();
		gap_pct   = 0;
		stall_pct = 0;
		write_register(REG_SIDE_LOG2, 16'd3);
		write_register(REG_SEED_LOG2, 16'd1);
		write_register(REG_INIT_SCALE, 16'd8192);
		hold_wanted = 1'b1;
		send_sample(draw_value(), 1'b1);
		for (int i = 0; i < 29; i++) send_sample(draw_value(), 1'b0);
		wait_idle();
	endtask

	// Random settings, each followed by one to three maps with random samples.
	// Most maps are small so that many complete within the budget; large maps
	// are cut short and left to the next restart.
	task automatic test_random_maps();
		int          goal;
		int          map_cap;
		int          maps;
		int unsigned lg;
		logic [3:0]  side_v;
		logic [3:0]  seed_v;
		logic [15:0] scale_v;
		goal = sent_count + RANDOM_ITEMS;
		while (sent_count < goal) begin
			wait_idle();
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 15;
				default: stall_pct = 40;
			endcase
			case ($urandom_range(0, 19))
				0: side_v = 4'd0;
				1: side_v = 4'd15;
				2: side_v = 4'd5;
				default: side_v = 4'($urandom_range(1, 4));
			endcase
			lg = (side_v < 1) ? 1 : (side_v > MAX_SIDE_LOG2) ? MAX_SIDE_LOG2 : side_v;
			if ($urandom_range(0, 4) == 0) begin
				seed_v = 4'($urandom_range(0, 15));
			end else begin
				seed_v = 4'($urandom_range(1, lg));
			end
			case ($urandom_range(0, 5))
				0: scale_v = 16'd0;
				1: scale_v = 16'd32768;
				2: scale_v = 16'hFFFF;
				default: scale_v = 16'($urandom_range(0, 32768));
			endcase
			write_register(REG_SIDE_LOG2, {12'd0, side_v});
			write_register(REG_SEED_LOG2, {12'd0, seed_v});
			write_register(REG_INIT_SCALE, scale_v);
			map_cap = (lg >= 6) ? 150 : 2000;
			maps    = $urandom_range(1, 3);
			// The item budget also caps each map so the total stays near the goal.
			for (int m = 0; m < maps && sent_count < goal; m++) begin
				run_map((goal - sent_count < map_cap) ? goal - sent_count : map_cap,
					1'($urandom_range(0, 1)));
			end
		end
		wait_idle();
	endtask

	// Closing stretch with no idling on either side.
	task automatic test_quiet_tail();
		gap_pct   = 0;
		stall_pct = 0;
		write_register(REG_SIDE_LOG2, 16'd3);
		write_register(REG_SEED_LOG2, 16'd3);
		write_register(REG_INIT_SCALE, 16'd20000);
		run_map(2000, 1'b1);
		run_map(2000, 1'b0);
	endtask

	// Output side: random stall bursts, plus one long hold-off on request.
	initial begin : point_receiver
		int len;
		forever begin
			@(posedge clk);
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				point_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				point_stall <= 1'b0;
			end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
				len = $urandom_range(1, 15);
				point_stall <= 1'b1;
				repeat (len) @(posedge clk);
				point_stall <= 1'b0;
			end
		end
	end

	task automatic report_field(input string field, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want_v,
				got_v);
			mismatch_count++;
		end
	endtask

	// Every point taken from the output is checked against the oldest prediction.
	always @(posedge clk) begin : point_checker
		point_t want;
		if (arst_n && point_valid && !point_stall) begin
			if (pending_points.size() == 0) begin
				$display("%0t ns: unexpected point, expected none actual row %0d col %0d",
					$time, point.row, point.col);
				mismatch_count++;
			end else begin
				want = pending_points.pop_front();
				report_field("row", want.row, point.row);
				report_field("col", want.col, point.col);
				report_field("height", want.height, point.height);
				report_field("last", want.last, point.last);
			end
		end
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("TB_ERROR");
		$finish;
	end

	initial begin : main_sequence
		int waited;
		side_cfg  = RST_SIDE_LOG2;
		seed_cfg  = RST_SEED_LOG2;
		scale_cfg = RST_INIT_SCALE;
		start_map();
		restart_due = 1'b1;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_late_register_write();
		test_output_hold();
		test_random_maps();
		test_quiet_tail();

		sample_valid <= 1'b0;
		waited = 0;
		while (pending_points.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_points.size() == 0) begin
			$display("TB_OK");
		end else begin
			if (pending_points.size() != 0) begin
				$display("%0t ns: %0d expected points never arrived", $time,
					pending_points.size());
			end
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
